### design/lru_key_value_cache_top_defines.svh
// assertion macros used by the design checker file
`ifndef LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define LKVC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lkvc port check failed");

// next-cycle implication, disabled while reset is asserted
`define LKVC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lkvc port check failed");

`endif

### design/lkvc_pkg.sv
package lkvc_pkg;

    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0]         CAP_RESET  = 5'd16;
    localparam logic signed [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture a new transaction
        logic look;   // key compare and victim search
        logic upd;    // state update and result
    } t_dp_cmd;

endpackage

### design/lkvc_ctrl.sv
module lkvc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output lkvc_pkg::t_dp_cmd o_cmd
);
    import lkvc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    // a new transaction may enter while the previous one is being written back
    assign busy   = (r_state == S_LOOK);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = accept ? S_LOOK : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load = accept && i_rst_n;
        o_cmd.look = (r_state == S_LOOK);
        o_cmd.upd  = (r_state == S_UPD);
    end

endmodule

### design/lkvc_datapath.sv
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lkvc_pkg::t_dp_cmd                 i_cmd,
    input  logic                              i_action,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    input  logic                              i_cap_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cap_data,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_value_out
);
    import lkvc_pkg::*;

    localparam int RW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;

    // captured transaction
    logic                     r_action;
    logic signed [DATA_W-1:0] r_key;
    logic signed [DATA_W-1:0] r_value;

    // entry lanes; entries 0 .. count-1 are the valid ones
    logic signed [DATA_W-1:0] r_keys [ENTRIES];
    logic [RW-1:0]            r_rank [ENTRIES];
    logic signed [DATA_W-1:0] r_mem  [ENTRIES];
    logic signed [DATA_W-1:0] r_rdata;
    logic [CW-1:0]            r_count;
    logic [CAP_W-1:0]         r_cap;

    // lookup results
    logic          r_hit;
    logic [RW-1:0] r_hit_idx;
    logic [RW-1:0] r_hit_rank;
    logic          r_evict;
    logic [RW-1:0] r_vic_idx;

    // result registers
    logic                     r_out_valid;
    logic                     r_out_hit;
    logic signed [DATA_W-1:0] r_out_value;

    logic [ENTRIES-1:0] valid_vec;
    logic [ENTRIES-1:0] match_vec;
    logic               n_hit;
    logic [RW-1:0]      n_hit_idx;
    logic [RW-1:0]      n_hit_rank;
    logic [RW-1:0]      n_vic_idx;
    logic [RW-1:0]      last_rank;
    logic [EW-1:0]      eff_cap;
    logic               n_evict;
    logic [RW-1:0]      target;
    logic [RW-1:0]      thresh;
    logic               inc_all;
    logic               do_touch;
    logic               do_insert;

    assign last_rank = RW'(r_count - 1'b1);

    always_comb begin
        n_hit_idx  = '0;
        n_hit_rank = '0;
        n_vic_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            valid_vec[i] = (CW'(i) < r_count);
            match_vec[i] = valid_vec[i] && (r_keys[i] == r_key);
            if (match_vec[i]) begin
                n_hit_idx  = n_hit_idx | RW'(i);
                n_hit_rank = n_hit_rank | r_rank[i];
            end
            // the least recent entry holds rank count-1
            if (valid_vec[i] && (r_rank[i] == last_rank)) begin
                n_vic_idx = n_vic_idx | RW'(i);
            end
        end
        n_hit = |match_vec;
    end

    always_comb begin
        eff_cap = EW'(r_cap);
        if (r_cap == '0) begin
            eff_cap = EW'(1);
        end else if (eff_cap > EW'(ENTRIES)) begin
            eff_cap = EW'(ENTRIES);
        end
        n_evict = (EW'(r_count) >= eff_cap) || (r_count == CW'(ENTRIES));
    end

    // write-back controls: a miss reuses the victim slot or takes slot count
    always_comb begin
        if (r_hit) begin
            target = r_hit_idx;
        end else if (r_evict) begin
            target = r_vic_idx;
        end else begin
            target = r_count[RW-1:0];
        end
        thresh    = r_hit ? r_hit_rank : last_rank;
        inc_all   = !r_hit && !r_evict;
        do_touch  = i_cmd.upd && (r_hit || r_action);
        do_insert = i_cmd.upd && r_action && !r_hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_value  <= i_value;
        end
        if (i_cmd.look) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_hit_rank <= n_hit_rank;
            r_evict    <= n_evict;
            r_vic_idx  <= n_vic_idx;
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (do_touch) begin
                if (RW'(i) == target) begin
                    r_rank[i] <= '0;
                end else if (valid_vec[i] && (inc_all || (r_rank[i] < thresh))) begin
                    r_rank[i] <= r_rank[i] + 1'b1;
                end
            end
            if (do_insert && (RW'(i) == target)) begin
                r_keys[i] <= r_key;
            end
        end
        if (i_cmd.upd) begin
            r_out_hit <= r_hit;
            if (r_action) begin
                r_out_value <= r_value;
            end else begin
                r_out_value <= r_hit ? r_rdata : MISS_VALUE;
            end
        end
    end

    // value store
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_rdata <= r_mem[n_hit_idx];
        end
        if (i_cmd.upd && r_action) begin
            r_mem[target] <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cap_we) begin
                r_cap <= i_cap_data;
            end
            if (do_insert && inc_all) begin
                r_count <= r_count + 1'b1;
            end
            r_out_valid <= i_cmd.upd;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_hit       = r_out_hit;
    assign o_value_out = r_out_value;

endmodule

### design/lru_key_value_cache_top.sv
// fully associative key-value cache with least-recently-used replacement
// command channel: a transaction is taken at a rising edge with start high and
//   busy low; i_action selects get (0) or put (1), i_key and i_value carry it
// result channel: o_valid is high for exactly one cycle with o_hit and
//   o_value_out; the receiver cannot stall, so every result must be taken then
// capacity: i_cap_we with i_cap_data writes the capacity register at any edge,
//   intended only while no transaction is in flight
// timing: busy is high for the one cycle after an accepted transaction (key
//   compare across all entries and victim search); the following cycle writes
//   back recency, key and value and already accepts the next transaction
// overlap: a new transaction can be taken in the last one's write-back cycle,
//   not in its compare cycle: both use the entry registers and value store port
// result: o_valid is registered from the write-back state of the transaction
// reset: entry count cleared, capacity set to 16, no result pending; key and
//   value storage is not cleared and needs no sweep, so start is taken at once
module lru_key_value_cache_top #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_action,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    input  logic                              i_cap_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cap_data,
    output logic                              o_valid,
    output logic                              o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] o_value_out
);
    import lkvc_pkg::*;

    t_dp_cmd cmd;

    lkvc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_value     (i_value),
        .i_cap_we    (i_cap_we),
        .i_cap_data  (i_cap_data),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_value_out (o_value_out)
    );

endmodule

### design/lkvc_checker.sv
`include "lru_key_value_cache_top_defines.svh"

module lkvc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid
);

    // an accepted transaction always occupies the compare cycle
    `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // the compare cycle lasts exactly one cycle
    `LKVC_ASSERT_NEXT(a_busy_single, busy, !busy)

    // the compare cycle is followed by a result after the write-back cycle
    `LKVC_ASSERT_IMPL(a_busy_result, busy, ##2 o_valid)

    // no result without a compare cycle ahead of its write-back cycle
    `LKVC_ASSERT_IMPL(a_result_origin, o_valid, $past(busy, 2))

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid)
);

### tb/lkvc_checker.sv
`timescale 1ns / 1ps
module lkvc_tb_checker #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic                               i_action,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] i_value,
    input  logic                               i_cap_we,
    input  logic [lkvc_pkg::CAP_W-1:0]         i_cap_data,
    input  logic                               o_valid,
    input  logic                               o_hit,
    input  logic signed [lkvc_pkg::DATA_W-1:0] o_value_out,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_result_count,
    output int                                 o_hit_count,
    output int                                 o_evict_count
);
    import lkvc_pkg::*;

    localparam int RANK_W    = $clog2(ENTRIES);
    localparam int COUNT_W   = $clog2(ENTRIES + 1);
    localparam int EXP_DEPTH = 8;
    localparam int EXP_AW    = $clog2(EXP_DEPTH);

    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] value_out;
    } t_answer;

    // expected results in order of acceptance
    t_answer           expected_answers [EXP_DEPTH];
    logic [EXP_AW-1:0] exp_rd;
    logic [EXP_AW-1:0] exp_wr;
    int                exp_fill;

    // shadow copy of the cache contents
    logic [DATA_W-1:0]  line_key   [ENTRIES];
    logic [DATA_W-1:0]  line_value [ENTRIES];
    logic               line_valid [ENTRIES];
    logic [RANK_W-1:0]  line_rank  [ENTRIES];
    logic [COUNT_W-1:0] line_count;
    logic [CAP_W-1:0]   capacity_reg;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_hit_count    = 0;
        o_evict_count  = 0;
        exp_rd         = '0;
        exp_wr         = '0;
        exp_fill       = 0;
    end

    function automatic int usable_capacity();
        int c;
        c = int'(capacity_reg);
        if (c == 0) c = 1;
        if (c > ENTRIES) c = ENTRIES;
        return c;
    endfunction

    // move one line to the front, the lines that were ahead of it drop back a place
    function automatic void promote_line(input int idx);
        logic [RANK_W-1:0] old_rank;
        old_rank = line_rank[idx];
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i] && line_rank[i] < old_rank) line_rank[i] = line_rank[i] + 1'b1;
        end
        line_rank[idx] = '0;
    endfunction

    function automatic t_answer serve_transaction(input logic is_put,
                                                   input logic [DATA_W-1:0] key,
                                                   input logic [DATA_W-1:0] val);
        t_answer ans;
        int      found;
        int      victim;
        int      slot;
        found  = -1;
        victim = -1;
        slot   = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
        end
        if (!is_put) begin
            if (found >= 0) begin
                promote_line(found);
                ans.hit       = 1'b1;
                ans.value_out = line_value[found];
            end else begin
                ans.hit       = 1'b0;
                ans.value_out = MISS_VALUE;
            end
            return ans;
        end
        ans.hit       = (found >= 0);
        ans.value_out = val;
        if (found >= 0) begin
            line_value[found] = val;
            promote_line(found);
            return ans;
        end
        // a new key pushes out exactly one line, even when occupancy is above capacity
        if (int'(line_count) >= usable_capacity() || int'(line_count) >= ENTRIES) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (line_valid[i] && (victim < 0 || line_rank[i] > line_rank[victim])) victim = i;
            end
            if (victim >= 0) begin
                line_valid[victim] = 1'b0;
                line_rank[victim]  = '0;
                if (line_count != 0) line_count = line_count - 1'b1;
                o_evict_count++;
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && !line_valid[i]) slot = i;
        end
        if (slot < 0) return ans;
        for (int i = 0; i < ENTRIES; i++) begin
            if (line_valid[i]) line_rank[i] = line_rank[i] + 1'b1;
        end
        line_key[slot]   = key;
        line_value[slot] = val;
        line_valid[slot] = 1'b1;
        line_rank[slot]  = '0;
        line_count       = line_count + 1'b1;
        return ans;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                line_valid[i] = 1'b0;
                line_rank[i]  = '0;
            end
            line_count   = '0;
            capacity_reg = CAP_RESET;
            exp_rd       = '0;
            exp_wr       = '0;
            exp_fill     = 0;
        end else begin
            if (o_valid) begin
                o_result_count++;
                if (exp_fill == 0) begin
                    report_mismatch($sformatf("result with nothing outstanding: hit %0b value %h",
                                              o_hit, o_value_out));
                end else begin
                    want     = expected_answers[exp_rd];
                    exp_rd   = exp_rd + 1'b1;
                    exp_fill = exp_fill - 1;
                    if (o_hit !== want.hit)
                        report_mismatch($sformatf("hit expected %0b got %0b",
                                                  want.hit, o_hit));
                    if (o_value_out !== want.value_out)
                        report_mismatch($sformatf("value_out expected %h got %h",
                                                  want.value_out, o_value_out));
                end
            end
            if (i_cap_we) capacity_reg = i_cap_data;
            if (start && !busy) begin
                want = serve_transaction(i_action, i_key, i_value);
                if (want.hit) o_hit_count++;
                if (exp_fill >= EXP_DEPTH) begin
                    report_mismatch("too many transactions outstanding");
                end else begin
                    expected_answers[exp_wr] = want;
                    exp_wr   = exp_wr + 1'b1;
                    exp_fill = exp_fill + 1;
                end
            end
        end
        o_pending = exp_fill;
    end

endmodule

### tb/tb_lru_key_value_cache_top.sv
`timescale 1ns / 1ps
module tb_lru_key_value_cache_top;
    import lkvc_pkg::*;

    localparam logic CMD_GET         = 1'b0;
    localparam logic CMD_PUT         = 1'b1;
    localparam int   PHASES          = 6;
    localparam int   ITEMS_PER_PHASE = 125;
    localparam int   QUIET_LIMIT     = 2000;
    localparam int   POOL_SIZE       = 32;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    logic                     i_action   = CMD_GET;
    logic signed [DATA_W-1:0] i_key      = '0;
    logic signed [DATA_W-1:0] i_value    = '0;
    logic                     i_cap_we   = 1'b0;
    logic [CAP_W-1:0]         i_cap_data = CAP_RESET;
    logic                     busy;
    logic                     o_valid;
    logic                     o_hit;
    logic signed [DATA_W-1:0] o_value_out;

    int mismatches;
    int outstanding;
    int results_seen;
    int hits_seen;
    int evictions_seen;
    int sender_idle_pct = 16;
    int quiet_cycles    = 0;
    int pool_span       = POOL_SIZE;

    logic [DATA_W-1:0] key_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    lru_key_value_cache_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_key       (i_key),
        .i_value     (i_value),
        .i_cap_we    (i_cap_we),
        .i_cap_data  (i_cap_data),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_value_out (o_value_out)
    );

    lkvc_tb_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_key          (i_key),
        .i_value        (i_value),
        .i_cap_we       (i_cap_we),
        .i_cap_data     (i_cap_data),
        .o_valid        (o_valid),
        .o_hit          (o_hit),
        .o_value_out    (o_value_out),
        .o_fail_count   (mismatches),
        .o_pending      (outstanding),
        .o_result_count (results_seen),
        .o_hit_count    (hits_seen),
        .o_evict_count  (evictions_seen)
    );

    // cycles with no transaction taken and no result delivered
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue_command(input logic act, input logic [DATA_W-1:0] key,
                                 input logic [DATA_W-1:0] val);
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_key    <= key;
        i_value  <= val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain_results();
        i_cap_we   <= 1'b1;
        i_cap_data <= cap;
        @(negedge i_clk);
        i_cap_we   <= 1'b0;
    endtask

    // mostly keys from a small working set so hits and evictions are frequent
    function automatic logic [DATA_W-1:0] pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 85) return key_pool[$urandom_range(pool_span - 1)];
        if (r < 93) return key_pool[$urandom_range(3)];
        return $urandom;
    endfunction

    initial begin
        logic [CAP_W-1:0] phase_cap  [PHASES];
        int               phase_idle [PHASES];
        int               eff_cap;

        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

        // 31 fills the whole store, 3 then drops capacity below occupancy
        phase_cap[0] = 5'd31;
        phase_cap[1] = 5'd3;
        phase_cap[2] = 5'd0;
        phase_cap[3] = CAP_W'($urandom_range(15, 2));
        phase_cap[4] = CAP_RESET;
        phase_cap[5] = 5'd1;
        phase_idle[0] = 16;
        phase_idle[1] = 16;
        phase_idle[2] = 53;
        phase_idle[3] = 53;
        phase_idle[4] = 0;
        phase_idle[5] = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: field extremes, hit versus miss, update, ignored value on get
        issue_command(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        issue_command(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
        issue_command(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
        issue_command(CMD_GET, 32'h8000_0000, $urandom);
        issue_command(CMD_GET, 32'h7fff_ffff, $urandom);
        issue_command(CMD_PUT, 32'h0000_0000, 32'hffff_ffff);
        issue_command(CMD_GET, 32'h0000_0000, 32'h0000_0000);
        issue_command(CMD_PUT, 32'h7fff_ffff, 32'h0000_0000);
        issue_command(CMD_GET, 32'h7fff_ffff, 32'hffff_ffff);
        issue_command(CMD_PUT, 32'hffff_ffff, 32'h0000_0001);
        issue_command(CMD_GET, 32'hffff_ffff, $urandom);
        issue_command(CMD_GET, 32'h5555_aaaa, $urandom);

        // occupancy four with capacity one: each new key pushes out a single line
        set_capacity(5'd1);
        issue_command(CMD_PUT, 32'h0000_0005, 32'h0000_0005);
        issue_command(CMD_GET, 32'h8000_0000, $urandom);
        issue_command(CMD_GET, 32'h0000_0000, $urandom);
        issue_command(CMD_PUT, 32'h0000_0006, 32'haaaa_5555);
        issue_command(CMD_GET, 32'h0000_0005, $urandom);

        for (int p = 0; p < PHASES; p++) begin
            set_capacity(phase_cap[p]);
            sender_idle_pct = phase_idle[p];
            eff_cap = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > 16) ? 16 : int'(phase_cap[p]);
            pool_span = (eff_cap + 4 > POOL_SIZE) ? POOL_SIZE : eff_cap + 4;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(1)) issue_command(CMD_PUT, pick_key(), $urandom);
                else issue_command(CMD_GET, pick_key(), $urandom);
            end
        end

        drain_results();
        $display("covered %0d transactions with %0d hits and %0d evictions",
                 results_seen, hits_seen, evictions_seen);
        $display("capacity 0 to 31 incl. drop below occupancy; sender gaps 16%%, 53%%, none");
        if (mismatches == 0 && outstanding == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/lkvc_pkg.sv
design/lkvc_ctrl.sv
design/lkvc_datapath.sv
design/lru_key_value_cache_top.sv
design/lkvc_checker.sv
tb/lkvc_checker.sv
tb/tb_lru_key_value_cache_top.sv
